// File: design/png_chunk_parser_crc_check_defines.svh
// Assertion macros shared by the PNG chunk parser files.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef PNG_CHUNK_PARSER_CRC_CHECK_DEFINES_SVH
`define PNG_CHUNK_PARSER_CRC_CHECK_DEFINES_SVH

// same-cycle implication, off during reset
`define PCPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcpc: implication check failed");

// next-cycle implication, off during reset
`define PCPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcpc: next-cycle check failed");

`endif

// File: design/pcpc_pkg.sv
// Shared types and constants of the PNG chunk parser.
// No dependencies.
package pcpc_pkg;

  localparam logic [31:0] TypeText = 32'h7445_5874;
  localparam logic [31:0] TypeIend = 32'h4945_4E44;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StCrcBad   = 2'd1;
  localparam logic [1:0] StNotPng   = 2'd2;
  localparam logic [1:0] StTruncate = 2'd3;

  typedef enum logic [2:0] {
    OP_SKIP,
    OP_LEN,
    OP_TYPE,
    OP_DATA,
    OP_CRC
  } op_e;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_CHUNK,
    EM_BADSIG,
    EM_TRUNC
  } emit_e;

  typedef struct packed {
    op_e         op;
    logic        first;
    emit_e       emit;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [31:0] computed_crc;
    logic [31:0] trailer_crc;
    logic        is_text;
    logic        is_end;
    logic        separator_found;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic        value_is_long;
  } result_t;

endpackage

// File: design/pcpc_front.sv
// Front end: accepts file bytes, tracks signature and chunk framing, and
// issues a classified request per byte that carries chunk framing, data or a report. Depends on pcpc_pkg.
module pcpc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic              full_i,
  output logic              ready_o,
  output logic              push_o,
  output pcpc_pkg::item_t   item_o
);

  localparam logic [2:0] PhSig  = 3'd0;
  localparam logic [2:0] PhLen  = 3'd1;
  localparam logic [2:0] PhType = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhCrc  = 3'd4;
  localparam logic [2:0] PhIdle = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] idx_q, idx_d;
  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic        match_q, match_d;
  logic        accept;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] res;
    case (idx)
      3'd0:    res = 8'h89;
      3'd1:    res = 8'h50;
      3'd2:    res = 8'h4E;
      3'd3:    res = 8'h47;
      3'd4:    res = 8'h0D;
      3'd5:    res = 8'h0A;
      3'd6:    res = 8'h1A;
      default: res = 8'h0A;
    endcase
    return res;
  endfunction

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign push_o  = accept && ((item_o.op != pcpc_pkg::OP_SKIP) ||
                              (item_o.emit != pcpc_pkg::EM_NONE));

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    len_d   = len_q;
    type_d  = type_q;
    match_d = match_q;
    item_o.op    = pcpc_pkg::OP_SKIP;
    item_o.first = 1'b0;
    item_o.emit  = pcpc_pkg::EM_NONE;
    item_o.data  = byte_i;
    case (phase_q)
      PhSig: begin
        match_d = match_q && (byte_i == sig_byte(idx_q[2:0]));
        idx_d   = idx_q + 32'd1;
        if (idx_q[2:0] == 3'd7) begin
          idx_d = '0;
          if (!match_d) begin
            item_o.emit = pcpc_pkg::EM_BADSIG;
            phase_d     = PhIdle;
          end else begin
            phase_d = PhLen;
          end
        end
      end
      PhLen: begin
        item_o.op = pcpc_pkg::OP_LEN;
        len_d     = {len_q[23:0], byte_i};
        idx_d     = idx_q + 32'd1;
        if (idx_q[1:0] == 2'd3) begin
          idx_d   = '0;
          phase_d = PhType;
        end
      end
      PhType: begin
        item_o.op    = pcpc_pkg::OP_TYPE;
        item_o.first = (idx_q[1:0] == 2'd0);
        type_d       = {type_q[23:0], byte_i};
        idx_d        = idx_q + 32'd1;
        if (idx_q[1:0] == 2'd3) begin
          idx_d   = '0;
          phase_d = (len_q != '0) ? PhData : PhCrc;
        end
      end
      PhData: begin
        item_o.op = pcpc_pkg::OP_DATA;
        if ((idx_q + 32'd1) == len_q) begin
          idx_d   = '0;
          phase_d = PhCrc;
        end else begin
          idx_d = idx_q + 32'd1;
        end
      end
      PhCrc: begin
        item_o.op = pcpc_pkg::OP_CRC;
        idx_d     = idx_q + 32'd1;
        if (idx_q[1:0] == 2'd3) begin
          item_o.emit = pcpc_pkg::EM_CHUNK;
          idx_d       = '0;
          phase_d     = (type_q == pcpc_pkg::TypeIend) ? PhIdle : PhLen;
        end
      end
      default: begin
      end
    endcase
    if (last_i) begin
      if (item_o.emit == pcpc_pkg::EM_NONE) begin
        if (phase_d == PhSig) begin
          item_o.emit = pcpc_pkg::EM_BADSIG;
        end else if ((phase_d != PhIdle) && !((phase_d == PhLen) && (idx_d == '0))) begin
          item_o.emit = pcpc_pkg::EM_TRUNC;
        end
      end
      phase_d = PhSig;
      idx_d   = '0;
      len_d   = '0;
      type_d  = '0;
      match_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSig;
      idx_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
      match_q <= 1'b1;
    end else if (accept) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      type_q  <= type_d;
      match_q <= match_d;
    end
  end

endmodule

// File: design/pcpc_queue.sv
// Short request queue between the front and back ends.
// Depends on pcpc_pkg for the request type.
module pcpc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcpc_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output pcpc_pkg::item_t item_o,
  input  logic            pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pcpc_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (do_pop) begin
        rd_q <= wrap_inc(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: design/pcpc_back.sv
// Back end: runs CRC-32, header and tEXt accounting per request and holds
// one result in an output register. Depends on pcpc_pkg.
module pcpc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pcpc_pkg::item_t   item_i,
  output logic              pop_o,
  input  logic [15:0]       limit_i,
  output logic              res_valid_o,
  output pcpc_pkg::result_t res_o,
  input  logic              res_ready_i
);

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] trl_q, trl_d;
  logic        sep_q, sep_d;
  logic [31:0] key_q, key_d;
  logic        vld_q, vld_d;
  pcpc_pkg::result_t res_q, res_d;
  logic        text, sep_ok;
  logic [31:0] computed, vlen;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  assign pop_o = valid_i && (!vld_q || res_ready_i);

  always_comb begin
    len_d  = len_q;
    type_d = type_q;
    crc_d  = crc_q;
    trl_d  = trl_q;
    sep_d  = sep_q;
    key_d  = key_q;
    case (item_i.op)
      pcpc_pkg::OP_LEN: begin
        len_d = {len_q[23:0], item_i.data};
      end
      pcpc_pkg::OP_TYPE: begin
        type_d = {type_q[23:0], item_i.data};
        crc_d  = crc_byte(item_i.first ? 32'hFFFF_FFFF : crc_q, item_i.data);
        if (item_i.first) begin
          sep_d = 1'b0;
          key_d = '0;
        end
      end
      pcpc_pkg::OP_DATA: begin
        crc_d = crc_byte(crc_q, item_i.data);
        if (!sep_q) begin
          if (item_i.data == 8'd0) begin
            sep_d = 1'b1;
          end else begin
            key_d = key_q + 32'd1;
          end
        end
      end
      pcpc_pkg::OP_CRC: begin
        trl_d = {trl_q[23:0], item_i.data};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    computed = ~crc_d;
    text     = (type_d == pcpc_pkg::TypeText) && (len_d != '0);
    sep_ok   = text && sep_d;
    vlen     = sep_ok ? (len_d - key_d - 32'd1) : '0;
    res_d    = '0;
    case (item_i.emit)
      pcpc_pkg::EM_CHUNK: begin
        res_d.status          = (computed == trl_d) ? pcpc_pkg::StOk : pcpc_pkg::StCrcBad;
        res_d.chunk_type      = type_d;
        res_d.chunk_length    = len_d;
        res_d.computed_crc    = computed;
        res_d.trailer_crc     = trl_d;
        res_d.is_text         = text;
        res_d.is_end          = (type_d == pcpc_pkg::TypeIend);
        res_d.separator_found = sep_ok;
        res_d.key_length      = sep_ok ? key_d : '0;
        res_d.value_length    = vlen;
        res_d.value_is_long   = sep_ok && (vlen > {16'd0, limit_i});
      end
      pcpc_pkg::EM_BADSIG: begin
        res_d.status = pcpc_pkg::StNotPng;
      end
      pcpc_pkg::EM_TRUNC: begin
        res_d.status = pcpc_pkg::StTruncate;
      end
      default: begin
      end
    endcase
    if (pop_o && (item_i.emit != pcpc_pkg::EM_NONE)) begin
      vld_d = 1'b1;
    end else if (res_ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      len_q  <= len_d;
      type_q <= type_d;
      crc_q  <= crc_d;
      trl_q  <= trl_d;
      sep_q  <= sep_d;
      key_q  <= key_d;
      if (item_i.emit != pcpc_pkg::EM_NONE) begin
        res_q <= res_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// File: design/png_chunk_parser_crc_check.sv
// Throughput: one byte per cycle while the request queue has room; the CRC-32 byte update in the back end sets it.
// Result path: the closing byte's request is queued, then the back end registers the result and raises tvalid.
// A result waiting at the output does not stop input until the request queue fills.
// Reset: async active low clears framing, queue and output valid; limit returns to 64.
// Depends on pcpc_pkg, pcpc_front, pcpc_queue, pcpc_back and the defines header.
`include "png_chunk_parser_crc_check_defines.svh"
module png_chunk_parser_crc_check #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] chunk_type, [63:32] chunk_length, [95:64] computed_crc,
  // [127:96] trailer_crc, [128] is_text, [129] is_end, [130] separator_found,
  // [162:131] key_length, [194:163] value_length, [195] value_is_long, zero pad
  output logic [199:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,  // [1:0] status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  logic [15:0]       limit_q;
  logic              push, full, q_valid, pop;
  pcpc_pkg::item_t   f_item, q_item;
  pcpc_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  pcpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .full_i  (full),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .item_o  (f_item)
  );

  pcpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  pcpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .limit_i     (limit_q),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {4'd0, res.value_is_long, res.value_length, res.key_length,
                         res.separator_found, res.is_end, res.is_text, res.trailer_crc,
                         res.computed_crc, res.chunk_length, res.chunk_type};

  `PCPC_ASSERT_IMP(a_status_only_zero,
    m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == '0)
  `PCPC_ASSERT_IMP(a_ok_crc_match,
    m_axis_tvalid && (m_axis_tuser == pcpc_pkg::StOk), res.computed_crc == res.trailer_crc)
  `PCPC_ASSERT_IMP(a_sep_needs_text,
    m_axis_tvalid && res.separator_found, res.is_text)
  `PCPC_ASSERT_IMP(a_long_needs_sep,
    m_axis_tvalid && res.value_is_long, res.separator_found)

endmodule

// File: bench/tb.sv
// Self-checking bench for png_chunk_parser_crc_check: byte stream in, one report per chunk or bad file out.
// Builds PNG files (directed table, then random files), predicts or pins each report, checks field by field.
// Depends on pcpc_pkg and the parser RTL.
`timescale 1ns / 1ps
module tb;

  typedef enum logic [2:0] {
    PARSE_SIG,
    PARSE_LEN,
    PARSE_TYPE,
    PARSE_DATA,
    PARSE_CRC,
    PARSE_IDLE
  } parse_e;

  typedef struct packed {
    logic [7:0]        b;
    logic              last;
    logic              fixed;
    pcpc_pkg::result_t want;
  } row_t;

  localparam logic [63:0] PngMagic = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] TypeHdr  = 32'h4948_4452;
  localparam logic [31:0] CrcPoly  = 32'hEDB8_8320;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  // predictor state
  parse_e      walk;
  logic [31:0] pos;
  logic [31:0] hdr_len;
  logic [31:0] hdr_type;
  logic [31:0] crc_acc;
  logic [31:0] crc_tail;
  logic        zero_seen;
  logic [31:0] key_cnt;
  logic        sig_ok;
  logic [15:0] value_limit = 16'd64;

  row_t              plan[$];
  logic [7:0]        body_q[$];
  pcpc_pkg::result_t reports_due[$];
  int unsigned       fails = 0;
  bit                calm_in = 1'b0;
  bit                calm_out = 1'b0;
  int unsigned       hold_left = 0;

  png_chunk_parser_crc_check u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic [31:0] crc32_next(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
    end
    return x;
  endfunction

  function automatic pcpc_pkg::result_t status_only(logic [1:0] s);
    pcpc_pkg::result_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  function automatic pcpc_pkg::result_t iend_report();
    pcpc_pkg::result_t r;
    r = '0;
    r.status       = pcpc_pkg::StOk;
    r.chunk_type   = pcpc_pkg::TypeIend;
    r.computed_crc = 32'hAE42_6082;
    r.trailer_crc  = 32'hAE42_6082;
    r.is_end       = 1'b1;
    return r;
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic clear_walk();
    walk      = PARSE_SIG;
    pos       = '0;
    hdr_len   = '0;
    hdr_type  = '0;
    crc_acc   = '1;
    crc_tail  = '0;
    zero_seen = 1'b0;
    key_cnt   = '0;
    sig_ok    = 1'b1;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last,
                              output logic got, output pcpc_pkg::result_t r);
    logic [31:0] computed;
    logic        text;
    logic        sep;
    logic [31:0] vlen;
    got = 1'b0;
    r = '0;
    case (walk)
      PARSE_SIG: begin
        if (b != PngMagic[63 - 8 * int'(pos[2:0]) -: 8]) sig_ok = 1'b0;
        pos++;
        if (pos >= 8) begin
          if (!sig_ok) begin
            got = 1'b1;
            r = status_only(pcpc_pkg::StNotPng);
            walk = PARSE_IDLE;
          end else begin
            walk = PARSE_LEN;
            pos = '0;
            hdr_len = '0;
          end
        end
      end
      PARSE_LEN: begin
        hdr_len = {hdr_len[23:0], b};
        pos++;
        if (pos >= 4) begin
          walk = PARSE_TYPE;
          pos = '0;
          hdr_type = '0;
          crc_acc = '1;
        end
      end
      PARSE_TYPE: begin
        hdr_type = {hdr_type[23:0], b};
        crc_acc = crc32_next(crc_acc, b);
        pos++;
        if (pos >= 4) begin
          pos = '0;
          zero_seen = 1'b0;
          key_cnt = '0;
          crc_tail = '0;
          walk = (hdr_len != 0) ? PARSE_DATA : PARSE_CRC;
        end
      end
      PARSE_DATA: begin
        crc_acc = crc32_next(crc_acc, b);
        if (!zero_seen) begin
          if (b == 8'h00) zero_seen = 1'b1;
          else key_cnt++;
        end
        pos++;
        if (pos >= hdr_len) begin
          pos = '0;
          walk = PARSE_CRC;
        end
      end
      PARSE_CRC: begin
        crc_tail = {crc_tail[23:0], b};
        pos++;
        if (pos >= 4) begin
          computed = ~crc_acc;
          text = (hdr_type == pcpc_pkg::TypeText) && (hdr_len != 0);
          sep = text && zero_seen;
          vlen = sep ? (hdr_len - key_cnt - 32'd1) : 32'd0;
          got = 1'b1;
          r.status          = (computed == crc_tail) ? pcpc_pkg::StOk : pcpc_pkg::StCrcBad;
          r.chunk_type      = hdr_type;
          r.chunk_length    = hdr_len;
          r.computed_crc    = computed;
          r.trailer_crc     = crc_tail;
          r.is_text         = text;
          r.is_end          = (hdr_type == pcpc_pkg::TypeIend);
          r.separator_found = sep;
          r.key_length      = sep ? key_cnt : 32'd0;
          r.value_length    = vlen;
          r.value_is_long   = sep && (vlen > {16'h0, value_limit});
          if (hdr_type == pcpc_pkg::TypeIend) begin
            walk = PARSE_IDLE;
          end else begin
            walk = PARSE_LEN;
            pos = '0;
            hdr_len = '0;
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      if (!got) begin
        if (walk == PARSE_SIG) begin
          got = 1'b1;
          r = status_only(pcpc_pkg::StNotPng);
        end else if (walk != PARSE_IDLE && !(walk == PARSE_LEN && pos == 0)) begin
          got = 1'b1;
          r = status_only(pcpc_pkg::StTruncate);
        end
      end
      clear_walk();
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    row_t r;
    r = '0;
    r.b = b;
    plan.push_back(r);
  endtask

  task automatic end_file();
    row_t r;
    r = plan.pop_back();
    r.last = 1'b1;
    plan.push_back(r);
  endtask

  task automatic pin_tail(input pcpc_pkg::result_t want);
    row_t r;
    r = plan.pop_back();
    r.fixed = 1'b1;
    r.want = want;
    plan.push_back(r);
  endtask

  // bad_at < 0 keeps the signature intact
  task automatic add_sig(input int bad_at);
    logic [7:0] b;
    for (int i = 0; i < 8; i++) begin
      b = PngMagic[63 - 8 * i -: 8];
      if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      put_byte(b);
    end
  endtask

  task automatic add_chunk(input logic [31:0] ctype, input bit bad_crc);
    logic [31:0] len;
    logic [31:0] crc;
    len = body_q.size();
    crc = '1;
    for (int i = 0; i < 4; i++) put_byte(len[31 - 8 * i -: 8]);
    for (int i = 0; i < 4; i++) begin
      put_byte(ctype[31 - 8 * i -: 8]);
      crc = crc32_next(crc, ctype[31 - 8 * i -: 8]);
    end
    foreach (body_q[i]) begin
      put_byte(body_q[i]);
      crc = crc32_next(crc, body_q[i]);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ ($urandom | 32'h1);
    for (int i = 0; i < 4; i++) put_byte(crc[31 - 8 * i -: 8]);
  endtask

  task automatic fill_text(input int unsigned klen, input bit with_sep, input int unsigned vlen);
    body_q.delete();
    repeat (klen) body_q.push_back(8'($urandom_range(1, 255)));
    if (with_sep) begin
      body_q.push_back(8'h00);
      repeat (vlen) body_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic fill_random(input int unsigned n);
    body_q.delete();
    repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_chunk();
    int unsigned r;
    int unsigned len;
    int unsigned klen;
    logic [31:0] ctype;
    r = $urandom_range(0, 99);
    len = (r < 80) ? $urandom_range(0, 20) : (r < 95) ? $urandom_range(21, 40)
                                                     : $urandom_range(60, 90);
    r = $urandom_range(0, 99);
    ctype = (r < 45) ? pcpc_pkg::TypeText : (r < 48) ? pcpc_pkg::TypeIend : $urandom;
    if (ctype == pcpc_pkg::TypeText && len != 0 && $urandom_range(0, 4) != 0) begin
      klen = $urandom_range(0, len - 1);
      fill_text(klen, 1'b1, len - 1 - klen);
    end else if (ctype == pcpc_pkg::TypeText) begin
      fill_text(len, 1'b0, 0);
    end else begin
      fill_random(len);
    end
    add_chunk(ctype, $urandom_range(0, 9) == 0);
  endtask

  task automatic add_random_file();
    int unsigned kind;
    int unsigned first;
    int unsigned n;
    int unsigned cut;
    first = plan.size();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      n = $urandom_range(1, 16);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
    end else if (kind < 12) begin
      add_sig($urandom_range(0, 7));
      n = $urandom_range(0, 6);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
    end else if (kind < 18) begin
      // wild length and type header, then up to five more bytes before the file stops
      add_sig(-1);
      repeat (8) put_byte(8'($urandom_range(0, 255)));
      n = $urandom_range(0, 5);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
    end else begin
      add_sig(-1);
      n = $urandom_range(0, 4);
      repeat (n) add_random_chunk();
      if ($urandom_range(0, 3) != 0) begin
        fill_random(($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0);
        add_chunk(pcpc_pkg::TypeIend, $urandom_range(0, 9) == 0);
        n = $urandom_range(0, 4);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end
      if (kind < 34) begin
        cut = $urandom_range(first + 1, plan.size());
        while (plan.size() > cut) void'(plan.pop_back());
      end
    end
    end_file();
  endtask

  task automatic run_plan();
    row_t              row;
    int unsigned       gap;
    logic              got;
    pcpc_pkg::result_t res;
    while (plan.size() != 0) begin
      row = plan.pop_front();
      if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
      gap = pick_gap(calm_in);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= row.b;
      s_axis_tlast  <= row.last;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      predict_byte(row.b, row.last, got, res);
      if (row.fixed) reports_due.push_back(row.want);
      else if (got) reports_due.push_back(res);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic settle();
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    value_limit = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_report(input pcpc_pkg::result_t w);
    check_field("status", 32'(w.status), 32'(m_axis_tuser));
    check_field("chunk_type", w.chunk_type, m_axis_tdata[31:0]);
    check_field("chunk_length", w.chunk_length, m_axis_tdata[63:32]);
    check_field("computed_crc", w.computed_crc, m_axis_tdata[95:64]);
    check_field("trailer_crc", w.trailer_crc, m_axis_tdata[127:96]);
    check_field("is_text", 32'(w.is_text), 32'(m_axis_tdata[128]));
    check_field("is_end", 32'(w.is_end), 32'(m_axis_tdata[129]));
    check_field("separator_found", 32'(w.separator_found), 32'(m_axis_tdata[130]));
    check_field("key_length", w.key_length, m_axis_tdata[162:131]);
    check_field("value_length", w.value_length, m_axis_tdata[194:163]);
    check_field("value_is_long", 32'(w.value_is_long), 32'(m_axis_tdata[195]));
  endtask

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) calm_out <= !calm_out;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      hold_left <= pick_gap(calm_out);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reports_due.size() == 0) begin
        $error("chunk report with none pending: status %0d", m_axis_tuser);
        fails++;
      end else begin
        check_report(reports_due.pop_front());
      end
    end
  end

  initial begin
    clear_walk();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, limit at its reset value
    plan.delete();
    put_byte(8'h89);
    end_file();
    pin_tail(status_only(pcpc_pkg::StNotPng));
    add_sig(-1);
    end_file();
    add_sig(3);
    pin_tail(status_only(pcpc_pkg::StNotPng));
    put_byte(8'h89);
    put_byte(8'hFF);
    end_file();
    add_sig(-1);
    body_q.delete();
    add_chunk(TypeHdr, 1'b0);
    fill_text(3, 1'b1, 4);
    add_chunk(pcpc_pkg::TypeText, 1'b0);
    fill_text(5, 1'b0, 0);
    add_chunk(pcpc_pkg::TypeText, 1'b0);
    body_q.delete();
    add_chunk(pcpc_pkg::TypeText, 1'b0);
    fill_text(0, 1'b1, 2);
    add_chunk(pcpc_pkg::TypeText, 1'b0);
    body_q.delete();
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    add_chunk(32'hFFFF_FFFF, 1'b1);
    body_q.delete();
    body_q.push_back(8'hFF);
    add_chunk(32'h0000_0000, 1'b0);
    body_q.delete();
    add_chunk(pcpc_pkg::TypeIend, 1'b0);
    pin_tail(iend_report());
    put_byte(8'h00);
    put_byte(8'hFF);
    end_file();
    add_sig(-1);
    fill_text(2, 1'b1, 3);
    add_chunk(pcpc_pkg::TypeText, 1'b0);
    end_file();
    add_sig(-1);
    repeat (4) put_byte(8'hFF);
    put_byte(8'h74);
    put_byte(8'h45);
    put_byte(8'h58);
    put_byte(8'h74);
    put_byte(8'h00);
    put_byte(8'h01);
    end_file();
    pin_tail(status_only(pcpc_pkg::StTruncate));
    add_sig(-1);
    put_byte(8'h00);
    put_byte(8'h00);
    end_file();
    pin_tail(status_only(pcpc_pkg::StTruncate));
    run_plan();

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: write_limit(16'hFFFF);
        1: write_limit(16'h0000);
        2: write_limit(16'h0001);
        3: write_limit(16'($urandom_range(2, 40)));
        default: write_limit(16'd64);
      endcase
      plan.delete();
      while (plan.size() < 190) add_random_file();
      run_plan();
    end

    settle();
    if (fails == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
